// ===== rtl/cco_pkg.sv =====
package cco_pkg;

    localparam int unsigned WORD_W = 32;
    localparam logic [WORD_W-1:0] ALL_ONES = '1;

    typedef enum logic [2:0] {
        ST_OK              = 3'd0,
        ST_PSEUDO_MISMATCH = 3'd1,
        ST_REAL_ON_NULL    = 3'd2,
        ST_OUT_OF_RANGE    = 3'd3,
        ST_INVALID_RANGE   = 3'd4
    } cco_status_t;

    // One dimension request, major to minor.
    typedef struct packed {
        logic signed [WORD_W-1:0] coordinate;
        logic [WORD_W-1:0]        range_left;
        logic [WORD_W-1:0]        range_right;
        logic                     last_dim;
    } cco_dim_t;

    // One offset result, given on the minor-most dimension.
    typedef struct packed {
        logic [WORD_W-1:0] cell_offset;
        logic [2:0]        status;
    } cco_result_t;

    // Decoded dimension, passed from the classifier to the accumulator.
    typedef struct packed {
        logic              update;
        cco_status_t       code;
        logic [WORD_W-1:0] card;
        logic [WORD_W-1:0] delta;
        logic              last_dim;
    } cco_term_t;

endpackage

// ===== rtl/cco_classify.sv =====
module cco_classify
    import cco_pkg::*;
(
    input  cco_dim_t  dim,
    output cco_term_t term
);

    logic [WORD_W-1:0] coord_u;
    logic              pseudo;
    logic              null_rng;

    assign coord_u  = WORD_W'(dim.coordinate);
    assign pseudo   = (coord_u == ALL_ONES);
    assign null_rng = (dim.range_left == ALL_ONES) && (dim.range_right == ALL_ONES);

    // The checks are ordered; only the first one that fires gives the code.
    always_comb
    begin
        term.update   = 1'b0;
        term.code     = ST_OK;
        term.card     = dim.range_right - dim.range_left + WORD_W'(1);
        term.delta    = coord_u - dim.range_left;
        term.last_dim = dim.last_dim;
        if (pseudo)
        begin
            if (!null_rng)
            begin
                term.code = ST_PSEUDO_MISMATCH;
            end
        end
        else if (null_rng)
        begin
            term.code = ST_REAL_ON_NULL;
        end
        else if (dim.range_right < dim.range_left)
        begin
            term.code = ST_INVALID_RANGE;
        end
        else if ((coord_u < dim.range_left) || (coord_u > dim.range_right))
        begin
            term.code = ST_OUT_OF_RANGE;
        end
        else
        begin
            term.update = 1'b1;
        end
    end

endmodule

// ===== rtl/cco_accum.sv =====
module cco_accum
    import cco_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        advance,
    input  cco_term_t   term,
    input  logic        res_ready,
    output logic        res_valid,
    output cco_result_t res
);

    logic [WORD_W-1:0] offset_reg;
    logic [WORD_W-1:0] offset_next;
    cco_status_t       error_reg;
    cco_status_t       error_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    cco_result_t       result_reg;
    cco_result_t       result_next;
    logic [WORD_W-1:0] product;
    logic [WORD_W-1:0] horner;
    cco_status_t       error_seen;

    // Horner step, modulo 2^32.
    assign product    = offset_reg * term.card;
    assign horner     = term.update ? (product + term.delta) : offset_reg;
    assign error_seen = (error_reg == ST_OK) ? term.code : error_reg;

    always_comb
    begin
        offset_next    = offset_reg;
        error_next     = error_reg;
        result_next    = result_reg;
        out_valid_next = out_valid_reg && !res_ready;
        if (advance)
        begin
            if (term.last_dim)
            begin
                offset_next             = '0;
                error_next              = ST_OK;
                result_next.cell_offset = (error_seen == ST_OK) ? horner : '0;
                result_next.status      = 3'(error_seen);
                out_valid_next          = 1'b1;
            end
            else
            begin
                offset_next = horner;
                error_next  = error_seen;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg    <= '0;
            error_reg     <= ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            offset_reg    <= offset_next;
            error_reg     <= error_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign res_valid = out_valid_reg;
    assign res       = result_reg;

`ifndef SYNTHESIS
    // A finished coordinate set leaves the running state cleared.
    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && term.last_dim) |=> (offset_reg == '0) && (error_reg == ST_OK))
        else $error("running state not cleared after last dimension");

    // Once an error is held it survives every non-last dimension.
    a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !term.last_dim && (error_reg != ST_OK)) |=> $stable(error_reg))
        else $error("held error was overwritten");

    // An erroneous result never reports a nonzero offset.
    a_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && (res.status != 3'(ST_OK))) |-> (res.cell_offset == '0))
        else $error("nonzero offset reported with error status");

    // A new result is only loaded when the old one is gone or being taken.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=> res_valid && $stable(res))
        else $error("pending result was overwritten");
`endif

endmodule

// ===== rtl/chunk_cell_offset.sv =====
// chunk_cell_offset: row-major cell offset of one coordinate set in a chunk.
// Requests arrive on the dim channel (dim_valid / dim_ready / dim), one per
// dimension, major to minor, with last_dim set on the minor-most dimension.
// A pseudo coordinate (-1) on a null range (both ends all-ones) is skipped;
// every other valid dimension folds into a running offset by Horner's rule,
// offset = offset * card + (coordinate - range_left), modulo 2^32.
// On the last dimension one result request leaves on the res channel
// (res_valid / res_ready / res) with the offset and the first error code
// seen in the set; the offset reads 0 whenever the status is not ok.
// Throughput is one dimension per cycle unless a last one waits on a full
// output register: the request is registered at acceptance, then one
// 32x32 multiply-add updates the running offset or loads the result.
// Reset clears the running offset, the held error and both valid flags.
// When the receiver stalls, the result stays in its output register;
// non-last dimensions of the next set keep flowing, and only a last
// dimension waits in the input register until the output frees up.
module chunk_cell_offset
    import cco_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        dim_valid,
    output logic        dim_ready,
    input  cco_dim_t    dim,
    output logic        res_valid,
    input  logic        res_ready,
    output cco_result_t res
);

    logic      hold_valid_reg;
    logic      hold_valid_next;
    cco_dim_t  hold_reg;
    cco_term_t term;
    logic      advance;

    // The held request moves on unless it would produce a result while the
    // output register is still occupied by one the receiver has not taken.
    assign advance   = hold_valid_reg && (!hold_reg.last_dim || !res_valid || res_ready);
    assign dim_ready = !hold_valid_reg || advance;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (dim_ready)
        begin
            hold_valid_next = dim_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dim_valid && dim_ready)
        begin
            hold_reg <= dim;
        end
    end

    cco_classify u_classify (
        .dim  (hold_reg),
        .term (term)
    );

    cco_accum u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .term      (term),
        .res_ready (res_ready),
        .res_valid (res_valid),
        .res       (res)
    );

endmodule

// ===== sim/cco_checker.sv =====
`timescale 1ns / 100ps

module cco_checker
    import cco_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        dim_valid,
    input  logic        dim_ready,
    input  cco_dim_t    dim,
    input  logic        res_valid,
    input  logic        res_ready,
    input  cco_result_t res,
    output int          outstanding,
    output int          mismatches
);

    cco_result_t       expected_offsets[$];
    cco_result_t       want;
    logic [WORD_W-1:0] horner_acc;
    cco_status_t       held_error;
    int                fault_count;

    task automatic report(input string msg);
        $display("cco_checker: %0t: %s", $realtime, msg);
        fault_count++;
    endtask

    // Folds one accepted dimension into the running offset; the minor-most
    // dimension closes the set and queues the offset it should produce.
    task automatic fold_dimension(input cco_dim_t d);
        logic [WORD_W-1:0] coord;
        logic              pseudo;
        logic              null_level;
        cco_status_t       code;
        cco_result_t       r;
        coord      = d.coordinate;
        pseudo     = (coord == ALL_ONES);
        null_level = (d.range_left == ALL_ONES) && (d.range_right == ALL_ONES);
        code       = ST_OK;
        if (pseudo)
        begin
            if (!null_level)
                code = ST_PSEUDO_MISMATCH;
        end
        else if (null_level)
            code = ST_REAL_ON_NULL;
        else if (d.range_right < d.range_left)
            code = ST_INVALID_RANGE;
        else if (coord < d.range_left || coord > d.range_right)
            code = ST_OUT_OF_RANGE;
        else
            horner_acc = horner_acc * (d.range_right - d.range_left + 1'b1)
                         + (coord - d.range_left);
        if (held_error == ST_OK)
            held_error = code;
        if (d.last_dim)
        begin
            r.cell_offset = (held_error == ST_OK) ? horner_acc : '0;
            r.status      = held_error;
            expected_offsets.insert(expected_offsets.size(), r);
            horner_acc = '0;
            held_error = ST_OK;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_offsets.delete();
            horner_acc  = '0;
            held_error  = ST_OK;
            fault_count = 0;
            outstanding <= 0;
            mismatches  <= 0;
        end
        else
        begin
            if (res_valid && res_ready)
            begin
                if (expected_offsets.size() == 0)
                    report($sformatf("unexpected result, offset %h status %0d",
                                     res.cell_offset, res.status));
                else
                begin
                    want = expected_offsets.pop_front();
                    if (res.cell_offset !== want.cell_offset)
                        report($sformatf("cell_offset %h, expected %h",
                                         res.cell_offset, want.cell_offset));
                    if (res.status !== want.status)
                        report($sformatf("status %0d, expected %0d",
                                         res.status, want.status));
                end
            end
            if (dim_valid && dim_ready)
                fold_dimension(dim);
            outstanding <= expected_offsets.size();
            mismatches  <= fault_count;
        end
    end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps

// Top of the offset testbench. This module only produces requests, applies
// back-pressure on the result side and gives the verdict; the checker beside
// the block predicts every offset and counts the mismatches.
module tb;

    import cco_pkg::*;

    // Generous bound: every request may see a long sender gap and a long
    // receiver stall, and the run still ends far below this.
    localparam int unsigned LIMIT_CYCLES = 400_000;
    localparam int unsigned RANDOM_DIMS  = 800;

    logic        clk;
    logic        rst_n;
    logic        dim_valid;
    logic        dim_ready;
    cco_dim_t    dim;
    logic        res_valid;
    logic        res_ready;
    cco_result_t res;
    int          outstanding;
    int          mismatches;

    int unsigned cycle_count = 0;

    // While set, neither side inserts idle cycles, so the block also sees
    // long back-to-back stretches at full rate.
    bit          steady = 1'b0;

    cco_dim_t    directed_dims[$];

    chunk_cell_offset uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .dim_valid (dim_valid),
        .dim_ready (dim_ready),
        .dim       (dim),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    cco_checker u_checker
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .dim_valid   (dim_valid),
        .dim_ready   (dim_ready),
        .dim         (dim),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .outstanding (outstanding),
        .mismatches  (mismatches)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Watchdog: a hung handshake or a lost result ends here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Idle length shared by both sides: mostly none or short, now and then
    // long, and none at all during a steady stretch.
    function automatic int unsigned idle_cycles();
        int unsigned r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(4, 24);
    endfunction

    // Builds one random dimension request. A clean pick is a well-formed
    // in-range dimension or a skipped pseudo level; otherwise each of the
    // error cases and raw noise can turn up as well.
    function automatic cco_dim_t random_dim(input bit clean, input bit last);
        cco_dim_t          d;
        logic [WORD_W-1:0] lo;
        logic [WORD_W-1:0] hi;
        logic [WORD_W-1:0] c;
        logic [WORD_W-1:0] swap;
        int unsigned       pick;
        int unsigned       shape;
        pick = clean ? $urandom_range(0, 89) : $urandom_range(0, 99);
        lo   = $urandom_range(0, 2000);
        hi   = lo + $urandom_range(0, 15);
        if (pick < 84)
        begin
            // Mostly small ranges near zero, some anywhere in the word, and
            // once in a while the full word, whose cardinality wraps to 0.
            shape = $urandom_range(0, 19);
            if (shape < 3)
            begin
                lo = $urandom();
                hi = lo + $urandom_range(0, 255);
                if (hi < lo)
                    hi = ALL_ONES;
            end
            else if (shape < 6)
            begin
                lo = $urandom();
                hi = $urandom();
                if (hi < lo)
                begin
                    swap = lo;
                    lo   = hi;
                    hi   = swap;
                end
            end
            else if (shape == 6)
            begin
                lo = '0;
                hi = ALL_ONES;
            end
            c = lo + $urandom_range(0, hi - lo);
        end
        else if (pick < 90)
        begin
            c  = ALL_ONES;
            lo = ALL_ONES;
            hi = ALL_ONES;
        end
        else if (pick < 93)
            c = ALL_ONES;
        else if (pick < 95)
        begin
            c = $urandom();
            if (c == ALL_ONES)
                c = '0;
            lo = ALL_ONES;
            hi = ALL_ONES;
        end
        else if (pick < 97)
        begin
            lo = $urandom_range(1, 32'hFFFF_FFFE);
            hi = $urandom_range(0, lo - 1);
            c  = $urandom();
        end
        else if (pick < 99)
        begin
            lo = $urandom_range(1, 2000);
            hi = lo + $urandom_range(0, 50);
            shape = $urandom_range(0, 2);
            if (shape == 0)
                c = $urandom_range(0, lo - 1);
            else if (shape == 1)
                c = hi + 1 + $urandom_range(0, 1000);
            else
                c = $urandom_range(32'h8000_0000, 32'hFFFF_FFFE);
        end
        else
        begin
            c  = $urandom();
            lo = $urandom();
            hi = $urandom();
        end
        d.coordinate  = c;
        d.range_left  = lo;
        d.range_right = hi;
        d.last_dim    = last;
        return d;
    endfunction

    task automatic add_directed(input logic [WORD_W-1:0] coord,
                                input logic [WORD_W-1:0] left,
                                input logic [WORD_W-1:0] right,
                                input logic              last);
        cco_dim_t d;
        d.coordinate  = coord;
        d.range_left  = left;
        d.range_right = right;
        d.last_dim    = last;
        directed_dims.insert(directed_dims.size(), d);
    endtask

    // Presents one request and holds it until the block takes it. Valid is
    // left high so that a following request can go out with no bubble.
    task automatic send_dim(input cco_dim_t d);
        dim       <= d;
        dim_valid <= 1'b1;
        @(posedge clk);
        while (!dim_ready)
            @(posedge clk);
    endtask

    task automatic sender_gap();
        int unsigned g;
        g = idle_cycles();
        if (g != 0)
        begin
            dim_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    // Stops sending and waits until the checker holds no pending offset.
    task automatic drain_results();
        dim_valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    // Result side: ready most of the time, with stalls of random length.
    initial
    begin
        int unsigned g;
        res_ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            res_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            g = idle_cycles();
            if (g != 0)
            begin
                res_ready <= 1'b0;
                repeat (g) @(posedge clk);
            end
        end
    end

    initial
    begin
        int unsigned sent;
        int unsigned set_len;
        bit          clean;
        bit          paused_mid;
        sent       = 0;
        paused_mid = 1'b0;
        rst_n     <= 1'b0;
        dim_valid <= 1'b0;
        dim       <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A single dimension on a one-value range.
        add_directed(32'd0, 32'd0, 32'd0, 1'b1);
        // Two dimensions folded by Horner's rule: 3 * 4 + 3.
        add_directed(32'd5, 32'd2, 32'd9, 1'b0);
        add_directed(32'd3, 32'd0, 32'd3, 1'b1);
        // A pseudo level on a null range is skipped.
        add_directed(ALL_ONES, ALL_ONES, ALL_ONES, 1'b0);
        add_directed(32'd1, 32'd0, 32'd1, 1'b1);
        // A set made only of pseudo levels gives offset 0 and no error.
        add_directed(ALL_ONES, ALL_ONES, ALL_ONES, 1'b1);
        // Pseudo coordinate on a real range.
        add_directed(ALL_ONES, 32'd0, 32'd5, 1'b1);
        // Real coordinate on a null range.
        add_directed(32'd7, ALL_ONES, ALL_ONES, 1'b1);
        // Range with its right end below its left end.
        add_directed(32'd3, 32'd5, 32'd2, 1'b1);
        // Out of range first, then an invalid range: the first error stays.
        add_directed(32'd10, 32'd0, 32'd5, 1'b0);
        add_directed(32'd2, 32'd5, 32'd2, 1'b1);
        // A negative coordinate other than -1 compares as a huge value.
        add_directed(32'hFFFF_FFFB, 32'd0, 32'd5, 1'b1);
        // Coordinate below the left end.
        add_directed(32'd1, 32'd2, 32'd5, 1'b1);
        // Full-word ranges: the cardinality wraps to 0, and the largest
        // positive and most negative coordinates are both in range.
        add_directed(32'h7FFF_FFFF, 32'd0, ALL_ONES, 1'b0);
        add_directed(32'h8000_0000, 32'd0, ALL_ONES, 1'b1);
        // Only the right end all-ones, then a large range that wraps the sum.
        add_directed(32'hFFFF_FFFE, 32'hFFFF_FFFE, ALL_ONES, 1'b0);
        add_directed(32'd100, 32'd0, 32'd999, 1'b0);
        add_directed(32'h0001_2345, 32'h0001_0000, 32'hFFFF_0000, 1'b1);
        // Only the left end all-ones: an invalid range, not a null one.
        add_directed(32'd0, ALL_ONES, 32'd0, 1'b1);
        // Pseudo coordinate on a range whose right end alone is all-ones.
        add_directed(ALL_ONES, 32'd0, ALL_ONES, 1'b1);

        foreach (directed_dims[i])
        begin
            send_dim(directed_dims[i]);
            sender_gap();
        end
        drain_results();

        // Random coordinate sets: mostly clean sets with random ranges and
        // coordinates, the rest mixing in every error and raw noise.
        while (sent < RANDOM_DIMS)
        begin
            steady  = ($urandom_range(0, 9) < 2);
            clean   = ($urandom_range(0, 3) != 0);
            set_len = $urandom_range(1, 6);
            for (int unsigned i = 0; i < set_len; i++)
            begin
                send_dim(random_dim(clean, i == set_len - 1));
                sender_gap();
                sent++;
            end
            // Midway, let the block run completely dry once.
            if (!paused_mid && sent >= RANDOM_DIMS / 2)
            begin
                drain_results();
                paused_mid = 1'b1;
            end
        end
        steady = 1'b0;

        drain_results();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
